// ----- design/multi_led_blink_controller_unit_defines.svh -----
// Assertion helpers for the LED blink controller.
`ifndef MULTI_LED_BLINK_CONTROLLER_UNIT_DEFINES_SVH
`define MULTI_LED_BLINK_CONTROLLER_UNIT_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define MLBC_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define MLBC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/mlbc_pkg.sv -----
package mlbc_pkg;

  localparam int NUM_LEDS  = 4;
  localparam int TIME_BITS = 16;
  localparam int CNT_BITS  = TIME_BITS + 1;
  localparam int LED_IDX_W = (NUM_LEDS > 1) ? $clog2(NUM_LEDS) : 1;

  localparam int FUNC_W    = 2;
  localparam int ID_W      = 2;
  localparam int REPEAT_W  = 8;
  localparam int TICKS_W   = 16;
  localparam int LEVELS_W  = 4;
  localparam int IN_DATA_W = 48;
  localparam int OUT_DATA_W = 8;

  localparam logic [REPEAT_W-1:0] CONTINUOUS = 8'hFF;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_TICK  = 2'd0,
    FUNC_FLASH = 2'd1,
    FUNC_LEVEL = 2'd2,
    FUNC_NONE  = 2'd3
  } func_t;

  // controller -> datapath
  typedef struct packed {
    logic load;   // capture input transaction, clear LED index
    logic visit;  // advance the LED at the current index
    logic apply;  // apply a set_flash / set_level item
    logic push;   // load the output register
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic last_led;
    logic out_free;
  } status_t;

endpackage

// ----- design/mlbc_ctrl.sv -----
module mlbc_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  input  logic [1:0]        s_tuser,
  output logic              s_tready,
  input  mlbc_pkg::status_t status,
  output mlbc_pkg::cmd_t    cmd
);
  import mlbc_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_TICK   = 4'b0010,
    ST_APPLY  = 4'b0100,
    ST_FINISH = 4'b1000
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    s_tready   = 1'b0;
    case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.load = 1'b1;
          if (func_t'(s_tuser) == FUNC_TICK) begin
            state_next = ST_TICK;
          end else begin
            state_next = ST_APPLY;
          end
        end
      end
      ST_TICK: begin
        cmd.visit = 1'b1;
        if (status.last_led) begin
          state_next = ST_FINISH;
        end
      end
      ST_APPLY: begin
        cmd.apply  = 1'b1;
        state_next = ST_FINISH;
      end
      ST_FINISH: begin
        if (status.out_free) begin
          cmd.push   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

// ----- design/mlbc_datapath.sv -----
module mlbc_datapath (
  input  logic                               clk,
  input  logic                               rst,
  input  logic [1:0]                         s_tuser,
  input  logic [mlbc_pkg::IN_DATA_W-1:0]     s_tdata,
  input  mlbc_pkg::cmd_t                     cmd,
  output mlbc_pkg::status_t                  status,
  output logic                               m_tvalid,
  input  logic                               m_tready,
  output logic [mlbc_pkg::OUT_DATA_W-1:0]    m_tdata
);
  import mlbc_pkg::*;

  // captured item
  func_t                item_func;
  logic [ID_W-1:0]      item_id;
  logic [REPEAT_W-1:0]  item_repeat;
  logic [TICKS_W-1:0]   item_on;
  logic [TICKS_W-1:0]   item_off;
  logic                 item_drive;
  logic                 item_clear;

  // per-LED state
  logic [NUM_LEDS-1:0]  led_on;
  logic [REPEAT_W-1:0]  blinks_left    [NUM_LEDS];
  logic [TIME_BITS-1:0] on_time        [NUM_LEDS];
  logic [TIME_BITS-1:0] off_span       [NUM_LEDS];
  logic [CNT_BITS-1:0]  period_counter [NUM_LEDS];

  logic [LED_IDX_W-1:0] idx;
  logic [LED_IDX_W-1:0] sel;
  logic                 id_ok;

  logic [CNT_BITS-1:0]  cnt;
  logic [CNT_BITS-1:0]  cnt_dec;
  logic [CNT_BITS-1:0]  cnt_next;
  logic [REPEAT_W-1:0]  blinks_next;
  logic                 on_next;

  logic [NUM_LEDS+LEVELS_W-1:0] levels_ext;

  assign sel   = cmd.visit ? idx : LED_IDX_W'(item_id);
  assign id_ok = (32'(item_id) < NUM_LEDS);

  assign status.last_led = (idx == LED_IDX_W'(NUM_LEDS - 1));
  assign status.out_free = !m_tvalid || m_tready;

  // one LED's tick step
  always_comb begin
    cnt         = period_counter[sel];
    cnt_dec     = cnt - CNT_BITS'(1);
    cnt_next    = cnt;
    blinks_next = blinks_left[sel];
    on_next     = led_on[sel];
    if (cnt != '0) begin
      cnt_next = cnt_dec;
      if (cnt_dec == {1'b0, off_span[sel]}) begin
        on_next = 1'b0;
      end
    end else if (blinks_left[sel] != '0) begin
      on_next  = 1'b1;
      cnt_next = {1'b0, on_time[sel]} + {1'b0, off_span[sel]};
      if (blinks_left[sel] != CONTINUOUS) begin
        blinks_next = blinks_left[sel] - REPEAT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item_func   <= func_t'(s_tuser);
      item_id     <= s_tdata[1:0];
      item_repeat <= s_tdata[9:2];
      item_on     <= s_tdata[25:10];
      item_off    <= s_tdata[41:26];
      item_drive  <= s_tdata[42];
      item_clear  <= s_tdata[43];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx    <= '0;
      led_on <= '0;
      for (int n = 0; n < NUM_LEDS; n++) begin
        blinks_left[n]    <= '0;
        on_time[n]        <= '0;
        off_span[n]       <= '0;
        period_counter[n] <= '0;
      end
    end else begin
      if (cmd.load) begin
        idx <= '0;
      end else if (cmd.visit) begin
        idx <= idx + LED_IDX_W'(1);
      end

      if (cmd.visit) begin
        led_on[sel]         <= on_next;
        blinks_left[sel]    <= blinks_next;
        period_counter[sel] <= cnt_next;
      end else if (cmd.apply && id_ok) begin
        case (item_func)
          FUNC_FLASH: begin
            blinks_left[sel]    <= item_repeat;
            on_time[sel]        <= TIME_BITS'(item_on);
            off_span[sel]       <= TIME_BITS'(item_off);
            period_counter[sel] <= '0;
            led_on[sel]         <= 1'b0;
          end
          FUNC_LEVEL: begin
            led_on[sel] <= item_drive;
            if (item_clear) begin
              blinks_left[sel]    <= '0;
              on_time[sel]        <= '0;
              off_span[sel]       <= '0;
              period_counter[sel] <= '0;
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

  // only the first four LEDs are reported
  assign levels_ext = {{LEVELS_W{1'b0}}, led_on};

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.push) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      m_tdata <= {(OUT_DATA_W - LEVELS_W)'(0), levels_ext[LEVELS_W-1:0]};
    end
  end

endmodule

// ----- design/multi_led_blink_controller_unit.sv -----
// Channel   Direction  tdata / tuser contents
// s_axis    in         tuser: func; tdata: led_id, repeat_count, on_ticks, off_ticks,
//                      drive_level, clear_pattern
// m_axis    out        tdata: led_levels
//
// A tick transaction walks the LEDs one per cycle through the shared update logic;
// a set_flash / set_level item is applied in the single ST_APPLY state.
// A new item is accepted once the previous one has reached the output register,
// even while that result is still waiting for m_tready.
// rst (synchronous) clears all LED patterns and levels and empties the output register.
`include "multi_led_blink_controller_unit_defines.svh"

module multi_led_blink_controller_unit (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  // [1:0] led_id, [9:2] repeat_count, [25:10] on_ticks, [41:26] off_ticks,
  // [42] drive_level, [43] clear_pattern, [47:44] zero
  input  logic [mlbc_pkg::IN_DATA_W-1:0]     s_tdata,
  input  logic [1:0]                         s_tuser,   // [1:0] func
  output logic                               m_tvalid,
  input  logic                               m_tready,
  output logic [mlbc_pkg::OUT_DATA_W-1:0]    m_tdata    // [3:0] led_levels, [7:4] zero
);
  import mlbc_pkg::*;

  cmd_t    cmd;
  status_t status;

  mlbc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tuser  (s_tuser),
    .s_tready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  mlbc_datapath u_datapath (
    .clk      (clk),
    .rst      (rst),
    .s_tuser  (s_tuser),
    .s_tdata  (s_tdata),
    .cmd      (cmd),
    .status   (status),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  `MLBC_ASSERT_NEXT(a_busy_after_accept, clk, rst, s_tvalid && s_tready, !s_tready, "accepted a transaction while busy")
  `MLBC_ASSERT_NOW(a_one_cmd, clk, rst, 1'b1, $onehot0({cmd.load, cmd.visit, cmd.apply, cmd.push}), "conflicting datapath commands")
  `MLBC_ASSERT_NOW(a_push_free, clk, rst, cmd.push, !m_tvalid || m_tready, "result overwrote a pending transaction")
  `MLBC_ASSERT_NOW(a_rise_from_push, clk, rst, $rose(m_tvalid), $past(cmd.push), "output valid without a result")

endmodule

// ----- sim/tb_multi_led_blink_controller_unit.sv -----
`timescale 1ns / 1ps

module tb_multi_led_blink_controller_unit;
  import mlbc_pkg::*;

  localparam int LIMIT_CYCLES = 1000000;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 20;

  logic                  clk;
  logic                  rst;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata;
  logic [1:0]            s_tuser;
  logic                  m_tvalid;
  logic                  m_tready;
  logic [OUT_DATA_W-1:0] m_tdata;

  multi_led_blink_controller_unit dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Shadow of the LED state
  logic                led_lit    [NUM_LEDS];
  logic [REPEAT_W-1:0] runs_left  [NUM_LEDS];
  logic [TIME_BITS-1:0] t_on      [NUM_LEDS];
  logic [TIME_BITS-1:0] t_off     [NUM_LEDS];
  logic [CNT_BITS-1:0] period_cnt [NUM_LEDS];

  logic [LEVELS_W-1:0] level_q[$];
  logic [LEVELS_W-1:0] want_levels;
  int                  err_cnt = 0;
  bit                  idle_on = 1'b1;
  bit                  hold_req = 1'b0;
  int                  cycles = 0;

  function automatic void clear_pattern_state(int n);
    runs_left[n]  = '0;
    t_on[n]       = '0;
    t_off[n]      = '0;
    period_cnt[n] = '0;
  endfunction

  // Applies one item to the shadow state, returns the levels it should report.
  function automatic logic [LEVELS_W-1:0] predict_levels(
      func_t f, logic [ID_W-1:0] id, logic [REPEAT_W-1:0] rep,
      logic [TICKS_W-1:0] on_ticks, logic [TICKS_W-1:0] off_ticks,
      logic lvl, logic clr);
    logic [LEVELS_W-1:0] lv;
    lv = '0;
    case (f)
      FUNC_TICK: begin
        for (int n = 0; n < NUM_LEDS; n++) begin
          if (period_cnt[n] != '0) begin
            period_cnt[n] = period_cnt[n] - 1'b1;
            if (period_cnt[n] == CNT_BITS'(t_off[n]))
              led_lit[n] = 1'b0;
          end else if (runs_left[n] != '0) begin
            led_lit[n] = 1'b1;
            if (runs_left[n] != CONTINUOUS)
              runs_left[n] = runs_left[n] - 1'b1;
            period_cnt[n] = CNT_BITS'(t_on[n]) + CNT_BITS'(t_off[n]);
          end
        end
      end
      FUNC_FLASH: begin
        if (int'(id) < NUM_LEDS) begin
          runs_left[id]  = rep;
          t_on[id]       = TIME_BITS'(on_ticks);
          t_off[id]      = TIME_BITS'(off_ticks);
          period_cnt[id] = '0;
          led_lit[id]    = 1'b0;
        end
      end
      FUNC_LEVEL: begin
        if (int'(id) < NUM_LEDS) begin
          led_lit[id] = lvl;
          if (clr)
            clear_pattern_state(int'(id));
        end
      end
      default: ;
    endcase
    for (int n = 0; n < NUM_LEDS && n < LEVELS_W; n++)
      lv[n] = led_lit[n];
    return lv;
  endfunction

  // Mostly back-to-back, sometimes a short pause, rarely a long one
  function automatic int pick_gap();
    int r;
    if (!idle_on)
      return 0;
    r = $urandom_range(0, 99);
    if (r < 60)
      return 0;
    if (r < 92)
      return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [TICKS_W-1:0] pick_time();
    int r;
    r = $urandom_range(0, 99);
    if (r < 85)
      return TICKS_W'($urandom_range(0, 4));
    if (r < 95)
      return TICKS_W'($urandom_range(0, 40));
    return TICKS_W'($urandom_range(0, 65535));
  endfunction

  function automatic logic [REPEAT_W-1:0] pick_count();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10)
      return '0;
    if (r < 25)
      return CONTINUOUS;
    if (r < 85)
      return REPEAT_W'($urandom_range(1, 5));
    return REPEAT_W'($urandom);
  endfunction

  // s_tvalid is left high after a transaction; it only drops when a gap follows.
  task automatic send_item(func_t f, logic [ID_W-1:0] id, logic [REPEAT_W-1:0] rep,
                           logic [TICKS_W-1:0] on_ticks, logic [TICKS_W-1:0] off_ticks,
                           logic lvl, logic clr);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= f;
    s_tdata  <= {4'b0, clr, lvl, off_ticks, on_ticks, rep, id};
    do @(posedge clk); while (!s_tready);
    level_q.push_back(predict_levels(f, id, rep, on_ticks, off_ticks, lvl, clr));
  endtask

  // Ticks carry random content in the unused fields
  task automatic tick();
    send_item(FUNC_TICK, ID_W'($urandom), REPEAT_W'($urandom), TICKS_W'($urandom),
              TICKS_W'($urandom), 1'($urandom), 1'($urandom));
  endtask

  task automatic flash(logic [ID_W-1:0] id, logic [REPEAT_W-1:0] rep,
                       logic [TICKS_W-1:0] on_ticks, logic [TICKS_W-1:0] off_ticks);
    send_item(FUNC_FLASH, id, rep, on_ticks, off_ticks, 1'($urandom), 1'($urandom));
  endtask

  task automatic set_level(logic [ID_W-1:0] id, logic lvl, logic clr);
    send_item(FUNC_LEVEL, id, REPEAT_W'($urandom), TICKS_W'($urandom),
              TICKS_W'($urandom), lvl, clr);
  endtask

  task automatic random_item();
    int r;
    func_t f;
    r = $urandom_range(0, 99);
    if (r < 45)
      f = FUNC_TICK;
    else if (r < 65)
      f = FUNC_FLASH;
    else if (r < 90)
      f = FUNC_LEVEL;
    else
      f = FUNC_NONE;
    send_item(f, ID_W'($urandom), REPEAT_W'($urandom), TICKS_W'($urandom),
              TICKS_W'($urandom), 1'($urandom), 1'($urandom));
  endtask

  task automatic test_directed();
    tick();                                      // nothing armed after reset
    flash(2'd0, 8'd3, 16'd2, 16'd1);
    flash(2'd1, CONTINUOUS, 16'd0, 16'd0);       // zero-length period, on every tick
    flash(2'd2, 8'd0, 16'hFFFF, 16'd0);          // no blinks at all
    flash(2'd3, CONTINUOUS, 16'hFFFF, 16'hFFFF); // longest period, counter top bit
    repeat (5) tick();
    set_level(2'd2, 1'b1, 1'b0);
    set_level(2'd3, 1'b0, 1'b1);                 // clear while running
    set_level(2'd1, 1'b1, 1'b1);
    tick();
    tick();
    send_item(FUNC_NONE, 2'd3, 8'hFF, 16'hFFFF, 16'hFFFF, 1'b1, 1'b1);
    flash(2'd2, 8'd1, 16'd0, 16'd2);             // on time zero
    repeat (4) tick();
    flash(2'd0, 8'hFE, 16'd1, 16'd0);            // off time zero
    repeat (3) tick();
  endtask

  // Receiver holds off long enough for the input side to stall
  task automatic test_backpressure();
    hold_req = 1'b1;
    repeat (8) begin
      flash(ID_W'($urandom), pick_count(), pick_time(), pick_time());
      tick();
      tick();
    end
  endtask

  // Arm a few LEDs, then run them with ticks; some rounds without any idling
  task automatic test_blink_patterns();
    int n_ticks;
    for (int round = 0; round < 60; round++) begin
      idle_on = (round % 5 != 4);
      repeat ($urandom_range(1, 4))
        flash(ID_W'($urandom), pick_count(), pick_time(), pick_time());
      n_ticks = $urandom_range(12, 30);
      repeat (n_ticks) begin
        if ($urandom_range(0, 99) < 8)
          set_level(ID_W'($urandom), 1'($urandom), 1'($urandom));
        else
          tick();
      end
    end
    idle_on = 1'b1;
  endtask

  task automatic test_random_items();
    repeat (400) random_item();
  endtask

  // Result checker
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (level_q.size() == 0) begin
        $error("led_levels: no transaction expected, actual %h", m_tdata[LEVELS_W-1:0]);
        err_cnt++;
      end else begin
        want_levels = level_q.pop_front();
        if (m_tdata[LEVELS_W-1:0] !== want_levels) begin
          $error("led_levels: expected %h, actual %h", want_levels,
                 m_tdata[LEVELS_W-1:0]);
          err_cnt++;
        end
      end
    end
  end

  // Receiver
  initial begin
    int gap;
    m_tready <= 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        gap = pick_gap();
        if (gap > 0) begin
          m_tready <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
      m_tready <= 1'b1;
      @(posedge clk);
    end
  end

  initial begin
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > LIMIT_CYCLES) begin
        $display("tb_multi_led_blink_controller_unit: errors");
        $finish;
      end
    end
  end

  initial begin
    for (int n = 0; n < NUM_LEDS; n++) begin
      led_lit[n] = 1'b0;
      clear_pattern_state(n);
    end
    rst      <= 1'b1;
    s_tvalid <= 1'b0;
    s_tdata  <= '0;
    s_tuser  <= '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    test_directed();
    test_backpressure();
    test_blink_patterns();
    test_random_items();

    s_tvalid <= 1'b0;
    while (level_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_cnt == 0)
      $display("tb_multi_led_blink_controller_unit: clean");
    else
      $display("tb_multi_led_blink_controller_unit: errors");
    $finish;
  end

endmodule
